[src/sd_card_spi_init_sequencer_top_assert.svh]
// Assertion macros for the SD card SPI init sequencer.
`ifndef SD_CARD_SPI_INIT_SEQUENCER_TOP_ASSERT_SVH
`define SD_CARD_SPI_INIT_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication.
`define SDCI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sdci_pkg.sv]
package sdci_pkg;

    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [BYTE_W-1:0]    t_byte;
    typedef logic [STATUS_W-1:0]  t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0] t_cfg_data;
    typedef logic [4:0]           t_phase;
    typedef logic [2:0]           t_frame;
    typedef logic [1:0]           t_reply;

    localparam t_mode MODE_START = 2'd0;
    localparam t_mode MODE_BYTE  = 2'd1;
    localparam t_mode MODE_TICK  = 2'd2;

    localparam t_cfg_idx CFG_PREAMBLE  = 2'd0;
    localparam t_cfg_idx CFG_ACMD_WAIT = 2'd1;
    localparam t_cfg_idx CFG_POLL_LIM  = 2'd2;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_CMD8_ECHO  = 3'd1;
    localparam t_status ST_CMD58_CHK  = 3'd2;
    localparam t_status ST_CMD55_TO   = 3'd3;
    localparam t_status ST_ACMD41_TO  = 3'd4;
    localparam t_status ST_FINAL_OCR  = 3'd5;

    localparam t_phase PH_IDLE     = 5'd0;
    localparam t_phase PH_PRE      = 5'd1;
    localparam t_phase PH_F_CMD0   = 5'd2;
    localparam t_phase PH_P_CMD0   = 5'd3;
    localparam t_phase PH_F_CMD8   = 5'd4;
    localparam t_phase PH_P_CMD8   = 5'd5;
    localparam t_phase PH_R_CMD8   = 5'd6;
    localparam t_phase PH_F_CHK    = 5'd7;
    localparam t_phase PH_P_CHK    = 5'd8;
    localparam t_phase PH_R_CHK    = 5'd9;
    localparam t_phase PH_F_CMD55  = 5'd10;
    localparam t_phase PH_P_CMD55  = 5'd11;
    localparam t_phase PH_F_ACMD41 = 5'd12;
    localparam t_phase PH_W_ACMD41 = 5'd13;
    localparam t_phase PH_P_ACMD41 = 5'd14;
    localparam t_phase PH_F_OCR    = 5'd15;
    localparam t_phase PH_P_OCR    = 5'd16;
    localparam t_phase PH_R_OCR    = 5'd17;

    localparam t_frame FR_CMD0   = 3'd0;
    localparam t_frame FR_CMD8   = 3'd1;
    localparam t_frame FR_CMD58  = 3'd2;
    localparam t_frame FR_CMD55  = 3'd3;
    localparam t_frame FR_ACMD41 = 3'd4;

    localparam t_reply RP_ECHO8 = 2'd0;
    localparam t_reply RP_CHK58 = 2'd1;
    localparam t_reply RP_OCR58 = 2'd2;

    localparam logic [2:0] FRAME_LAST = 3'd5;
    localparam t_byte      IDLE_BYTE  = 8'hFF;
    localparam t_byte      R1_IDLE    = 8'h01;
    localparam t_byte      R1_READY   = 8'h00;

    function automatic t_byte frame_byte(input t_frame fr, input logic [2:0] idx);
        t_byte b;
        b = 8'h00;
        unique case (idx)
            3'd0: begin
                unique case (fr)
                    FR_CMD0:   b = 8'h40;
                    FR_CMD8:   b = 8'h48;
                    FR_CMD58:  b = 8'h7A;
                    FR_CMD55:  b = 8'h77;
                    FR_ACMD41: b = 8'h69;
                    default:   b = 8'h00;
                endcase
            end
            3'd1: b = (fr == FR_ACMD41) ? 8'h40 : 8'h00;
            3'd3: b = (fr == FR_CMD8) ? 8'h01 : 8'h00;
            3'd4: b = (fr == FR_CMD8) ? 8'hAA : 8'h00;
            3'd5: begin
                unique case (fr)
                    FR_CMD0: b = 8'h95;
                    FR_CMD8: b = 8'h87;
                    default: b = 8'h01;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic t_byte reply_byte(input t_reply rp, input logic [1:0] k);
        t_byte b;
        b = 8'h00;
        unique case (rp)
            RP_ECHO8: begin
                unique case (k)
                    2'd0: b = 8'h00;
                    2'd1: b = 8'h00;
                    2'd2: b = 8'h01;
                    default: b = 8'hAA;
                endcase
            end
            RP_CHK58: begin
                unique case (k)
                    2'd0: b = 8'hFF;
                    2'd1: b = 8'h80;
                    2'd2: b = 8'h00;
                    default: b = 8'hFF;
                endcase
            end
            default: begin
                unique case (k)
                    2'd0: b = 8'hC0;
                    2'd1: b = 8'hFF;
                    2'd2: b = 8'h80;
                    default: b = 8'h00;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

[src/sd_card_spi_init_sequencer_top.sv]
// SD card SPI-mode start-up sequencer. Each input word is a start request, a byte
// received from the card, or a timer tick; each yields at most one result word that
// carries the next byte to shift out and the chip-select level, or the end of the
// sequence with a status code (0 success, 1 CMD8 echo, 2 CMD58 check, 3 CMD55
// timeout, 4 ACMD41 timeout, 5 final OCR). The block takes one word per clock unless
// a result waits untaken; a word passes an input register and a result register, and
// it is held in the input register while a waiting result is not taken.
// Registers: 0 preamble byte count, 1 ACMD41 tick wait,
// 2 R1 poll limit; write them only while no sequence step is in flight.
`include "sd_card_spi_init_sequencer_top_assert.svh"

module sd_card_spi_init_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sdci_pkg::t_mode    i_mode,
    input  sdci_pkg::t_byte    i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sdci_pkg::t_byte    o_tx_byte,
    output logic               o_select_asserted,
    output logic               o_finished,
    output sdci_pkg::t_status  o_status,
    input  logic               i_cfg_wr_en,
    input  sdci_pkg::t_cfg_idx i_cfg_index,
    input  sdci_pkg::t_cfg_data i_cfg_data
);
    import sdci_pkg::*;

    logic [7:0]  r_preamble_bytes;
    logic [15:0] r_acmd_wait_ticks;
    logic [7:0]  r_poll_limit;

    logic        r_in_valid;
    t_mode       r_in_mode;
    t_byte       r_in_rx;

    t_phase      r_phase,      n_phase;
    logic [2:0]  r_frame_idx,  n_frame_idx;
    logic [1:0]  r_reply_idx,  n_reply_idx;
    logic [7:0]  r_poll_cnt,   n_poll_cnt;
    logic [7:0]  r_pre_cnt,    n_pre_cnt;
    logic [15:0] r_wait_cnt,   n_wait_cnt;

    logic        r_out_valid;
    t_byte       r_out_tx,     n_out_tx;
    logic        r_out_sel,    n_out_sel;
    logic        r_out_fin,    n_out_fin;
    t_status     r_out_status, n_out_status;
    logic        n_emit;

    logic        w_proc;
    logic        w_is_frame;
    t_frame      w_fr;
    t_phase      w_fr_next;
    t_reply      w_rp;
    logic        w_match;
    logic [7:0]  w_lim;
    logic [7:0]  w_poll_inc;
    logic        w_exhausted;
    logic [15:0] w_wait_inc;

    assign w_proc     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_proc;

    assign o_out_valid       = r_out_valid;
    assign o_tx_byte         = r_out_tx;
    assign o_select_asserted = r_out_sel;
    assign o_finished        = r_out_fin;
    assign o_status          = r_out_status;

    always_comb begin
        w_is_frame = 1'b1;
        w_fr       = FR_CMD0;
        w_fr_next  = PH_P_CMD0;
        w_rp       = RP_OCR58;
        unique case (r_phase)
            PH_F_CMD0:   begin w_fr = FR_CMD0;   w_fr_next = PH_P_CMD0;   end
            PH_F_CMD8:   begin w_fr = FR_CMD8;   w_fr_next = PH_P_CMD8;   end
            PH_F_CHK:    begin w_fr = FR_CMD58;  w_fr_next = PH_P_CHK;    end
            PH_F_CMD55:  begin w_fr = FR_CMD55;  w_fr_next = PH_P_CMD55;  end
            PH_F_ACMD41: begin w_fr = FR_ACMD41; w_fr_next = PH_P_ACMD41; end
            PH_F_OCR:    begin w_fr = FR_CMD58;  w_fr_next = PH_P_OCR;    end
            PH_R_CMD8:   begin w_is_frame = 1'b0; w_rp = RP_ECHO8; end
            PH_R_CHK:    begin w_is_frame = 1'b0; w_rp = RP_CHK58; end
            default:     w_is_frame = 1'b0;
        endcase
    end

    assign w_match     = (r_in_rx == reply_byte(w_rp, r_reply_idx));
    assign w_lim       = (r_poll_limit == 8'd0) ? 8'd1 : r_poll_limit;
    assign w_poll_inc  = (r_poll_cnt == 8'hFF) ? r_poll_cnt : r_poll_cnt + 8'd1;
    assign w_exhausted = (w_poll_inc >= w_lim);
    assign w_wait_inc  = r_wait_cnt + 16'd1;

    always_comb begin
        n_phase      = r_phase;
        n_frame_idx  = r_frame_idx;
        n_reply_idx  = r_reply_idx;
        n_poll_cnt   = r_poll_cnt;
        n_pre_cnt    = r_pre_cnt;
        n_wait_cnt   = r_wait_cnt;
        n_emit       = 1'b0;
        n_out_tx     = IDLE_BYTE;
        n_out_sel    = 1'b1;
        n_out_fin    = 1'b0;
        n_out_status = ST_OK;
        unique case (r_in_mode)
            MODE_START: begin
                n_frame_idx = 3'd0;
                n_reply_idx = 2'd0;
                n_poll_cnt  = 8'd0;
                n_wait_cnt  = 16'd0;
                n_emit      = 1'b1;
                if (r_preamble_bytes == 8'd0) begin
                    n_pre_cnt = 8'd0;
                    n_phase   = PH_F_CMD0;
                    n_out_tx  = frame_byte(FR_CMD0, 3'd0);
                end else begin
                    n_pre_cnt = 8'd1;
                    n_phase   = PH_PRE;
                    n_out_sel = 1'b0;
                end
            end
            MODE_TICK: begin
                if (r_phase == PH_W_ACMD41) begin
                    n_wait_cnt = w_wait_inc;
                    if (w_wait_inc >= r_acmd_wait_ticks) begin
                        n_phase    = PH_P_ACMD41;
                        n_poll_cnt = 8'd0;
                        n_emit     = 1'b1;
                    end
                end
            end
            MODE_BYTE: begin
                if (w_is_frame) begin
                    if (r_frame_idx < FRAME_LAST) begin
                        n_frame_idx = r_frame_idx + 3'd1;
                        n_emit      = 1'b1;
                        n_out_tx    = frame_byte(w_fr, r_frame_idx + 3'd1);
                    end else if (w_fr == FR_ACMD41 && r_acmd_wait_ticks != 16'd0) begin
                        n_wait_cnt = 16'd0;
                        n_phase    = PH_W_ACMD41;
                    end else begin
                        n_wait_cnt = (w_fr == FR_ACMD41) ? 16'd0 : r_wait_cnt;
                        n_phase    = w_fr_next;
                        n_poll_cnt = 8'd0;
                        n_emit     = 1'b1;
                    end
                end else begin
                    unique case (r_phase)
                        PH_PRE: begin
                            n_emit = 1'b1;
                            if (r_pre_cnt < r_preamble_bytes) begin
                                n_pre_cnt = r_pre_cnt + 8'd1;
                                n_out_sel = 1'b0;
                            end else begin
                                n_phase     = PH_F_CMD0;
                                n_frame_idx = 3'd0;
                                n_out_tx    = frame_byte(FR_CMD0, 3'd0);
                            end
                        end
                        PH_P_CMD0, PH_P_CMD8, PH_P_CHK, PH_P_OCR: begin
                            n_emit = 1'b1;
                            priority if (r_phase == PH_P_CMD0 && r_in_rx == R1_IDLE) begin
                                n_phase     = PH_F_CMD8;
                                n_frame_idx = 3'd0;
                                n_out_tx    = frame_byte(FR_CMD8, 3'd0);
                            end else if (r_phase == PH_P_CMD8 && r_in_rx == R1_IDLE) begin
                                n_phase     = PH_R_CMD8;
                                n_reply_idx = 2'd0;
                            end else if (r_phase == PH_P_CHK && r_in_rx == R1_READY) begin
                                n_phase     = PH_R_CHK;
                                n_reply_idx = 2'd0;
                            end else if (r_phase == PH_P_OCR && r_in_rx == R1_READY) begin
                                n_phase     = PH_R_OCR;
                                n_reply_idx = 2'd0;
                            end else begin
                                n_phase = r_phase;
                            end
                        end
                        PH_R_CMD8, PH_R_CHK, PH_R_OCR: begin
                            n_emit = 1'b1;
                            if (!w_match) begin
                                n_phase   = PH_IDLE;
                                n_out_tx  = 8'h00;
                                n_out_fin = 1'b1;
                                priority if (r_phase == PH_R_CMD8) begin
                                    n_out_status = ST_CMD8_ECHO;
                                end else if (r_phase == PH_R_CHK) begin
                                    n_out_status = ST_CMD58_CHK;
                                end else begin
                                    n_out_status = ST_FINAL_OCR;
                                end
                            end else if (r_reply_idx != 2'd3) begin
                                n_reply_idx = r_reply_idx + 2'd1;
                            end else if (r_phase == PH_R_OCR) begin
                                n_phase   = PH_IDLE;
                                n_out_tx  = 8'h00;
                                n_out_fin = 1'b1;
                            end else begin
                                n_phase     = (r_phase == PH_R_CMD8) ? PH_F_CHK : PH_F_CMD55;
                                n_frame_idx = 3'd0;
                                n_out_tx    = (r_phase == PH_R_CMD8) ?
                                              frame_byte(FR_CMD58, 3'd0) :
                                              frame_byte(FR_CMD55, 3'd0);
                            end
                        end
                        PH_P_CMD55: begin
                            n_emit = 1'b1;
                            if (r_in_rx <= R1_IDLE) begin
                                n_phase     = PH_F_ACMD41;
                                n_frame_idx = 3'd0;
                                n_out_tx    = frame_byte(FR_ACMD41, 3'd0);
                            end else begin
                                n_poll_cnt = w_poll_inc;
                                if (w_exhausted) begin
                                    n_phase      = PH_IDLE;
                                    n_out_tx     = 8'h00;
                                    n_out_fin    = 1'b1;
                                    n_out_status = ST_CMD55_TO;
                                end
                            end
                        end
                        PH_P_ACMD41: begin
                            n_emit = 1'b1;
                            priority if (r_in_rx == R1_READY) begin
                                n_phase     = PH_F_OCR;
                                n_frame_idx = 3'd0;
                                n_out_tx    = frame_byte(FR_CMD58, 3'd0);
                            end else if (r_in_rx == R1_IDLE) begin
                                n_phase     = PH_F_CMD55;
                                n_frame_idx = 3'd0;
                                n_out_tx    = frame_byte(FR_CMD55, 3'd0);
                            end else begin
                                n_poll_cnt = w_poll_inc;
                                if (w_exhausted) begin
                                    n_phase      = PH_IDLE;
                                    n_out_tx     = 8'h00;
                                    n_out_fin    = 1'b1;
                                    n_out_status = ST_ACMD41_TO;
                                end
                            end
                        end
                        default: n_emit = 1'b0;
                    endcase
                end
            end
            default: n_emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble_bytes  <= 8'd10;
            r_acmd_wait_ticks <= 16'd500;
            r_poll_limit      <= 8'd5;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_PREAMBLE:  r_preamble_bytes  <= i_cfg_data[7:0];
                CFG_ACMD_WAIT: r_acmd_wait_ticks <= i_cfg_data;
                CFG_POLL_LIM:  r_poll_limit      <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_mode <= i_mode;
            r_in_rx   <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_frame_idx <= 3'd0;
            r_reply_idx <= 2'd0;
            r_poll_cnt  <= 8'd0;
            r_pre_cnt   <= 8'd0;
            r_wait_cnt  <= 16'd0;
            r_out_valid <= 1'b0;
        end else if (w_proc) begin
            r_phase     <= n_phase;
            r_frame_idx <= n_frame_idx;
            r_reply_idx <= n_reply_idx;
            r_poll_cnt  <= n_poll_cnt;
            r_pre_cnt   <= n_pre_cnt;
            r_wait_cnt  <= n_wait_cnt;
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && n_emit) begin
            r_out_tx     <= n_out_tx;
            r_out_sel    <= n_out_sel;
            r_out_fin    <= n_out_fin;
            r_out_status <= n_out_status;
        end
    end

    `SDCI_ASSERT_NEXT(a_start_emits, i_clk, i_rst_n, w_proc && r_in_mode == MODE_START, r_out_valid && !r_out_fin, "start word gave no running result")
    `SDCI_ASSERT_NEXT(a_finish_idles, i_clk, i_rst_n, w_proc && n_emit && n_out_fin, r_phase == PH_IDLE, "finish did not return to idle")
    `SDCI_ASSERT_NOW(a_finish_form, i_clk, i_rst_n, r_out_valid && r_out_fin, r_out_sel && r_out_tx == 8'h00, "finish word malformed")
    `SDCI_ASSERT_NOW(a_status_ok, i_clk, i_rst_n, r_out_valid && !r_out_fin, r_out_status == ST_OK, "status set on running word")
    `SDCI_ASSERT_NOW(a_frame_idx, i_clk, i_rst_n, 1'b1, r_frame_idx <= FRAME_LAST, "frame byte index out of range")

endmodule

[verif/sd_card_spi_init_sequencer_top_tb.sv]
module sd_card_spi_init_sequencer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdci_pkg::*;

    localparam int        CYCLE_LIMIT  = 2_000_000;
    localparam int        SETTLE_LAT   = 8;
    localparam int        HOLD_CYCLES  = 300;
    localparam int        WORD_GOAL    = 1750;
    localparam t_mode     MODE_RSVD    = 2'd3;
    localparam t_cfg_idx  CFG_UNUSED   = 2'd3;

    typedef struct packed {
        t_byte   tx;
        logic    sel;
        logic    fin;
        t_status st;
    } t_spi_word;

    typedef enum int {MATCH_FAIL, MATCH_MORE, MATCH_DONE} t_match;
    typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY} t_stall;

    class init_seq_scoreboard;
        t_spi_word   expected[$];
        int          errors;
        int          predicted;
        int          predicted_finishes;
        int          noted;

        logic [7:0]  pre_bytes;
        logic [15:0] wait_ticks;
        logic [7:0]  poll_lim;

        t_phase      phase;
        logic [2:0]  frame_pos;
        logic [1:0]  reply_pos;
        logic [7:0]  polls;
        logic [7:0]  pre_sent;
        logic [15:0] ticks_seen;

        t_byte       cmd_frames [5][6];
        t_byte       reply_tbl [3][4];

        function new();
            errors = 0;
            predicted = 0;
            predicted_finishes = 0;
            noted = 0;
            pre_bytes = 8'd10;
            wait_ticks = 16'd500;
            poll_lim = 8'd5;
            phase = PH_IDLE;
            frame_pos = '0;
            reply_pos = '0;
            polls = '0;
            pre_sent = '0;
            ticks_seen = '0;
            cmd_frames = '{'{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h95},
                           '{8'h48, 8'h00, 8'h00, 8'h01, 8'hAA, 8'h87},
                           '{8'h7A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01},
                           '{8'h77, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01},
                           '{8'h69, 8'h40, 8'h00, 8'h00, 8'h00, 8'h01}};
            reply_tbl = '{'{8'h00, 8'h00, 8'h01, 8'hAA},
                          '{8'hFF, 8'h80, 8'h00, 8'hFF},
                          '{8'hC0, 8'hFF, 8'h80, 8'h00}};
        endfunction

        function void write_cfg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                CFG_PREAMBLE:  pre_bytes = data[7:0];
                CFG_ACMD_WAIT: wait_ticks = data;
                CFG_POLL_LIM:  poll_lim = data[7:0];
                default: ;
            endcase
        endfunction

        function void push(t_byte tx, logic sel, logic fin, t_status st);
            expected.push_back('{tx: tx, sel: sel, fin: fin, st: st});
            predicted++;
            if (fin)
                predicted_finishes++;
        endfunction

        function void finish_seq(t_status st);
            phase = PH_IDLE;
            push(8'h00, 1'b1, 1'b1, st);
        endfunction

        function void start_frame(t_phase ph, t_frame fr);
            phase = ph;
            frame_pos = '0;
            push(cmd_frames[fr][0], 1'b1, 1'b0, ST_OK);
        endfunction

        function void start_poll(t_phase ph);
            phase = ph;
            polls = '0;
            push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
        endfunction

        function void start_reply(t_phase ph);
            phase = ph;
            reply_pos = '0;
            push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
        endfunction

        function void next_frame_byte(t_frame fr, t_phase poll_ph);
            if (frame_pos < FRAME_LAST) begin
                frame_pos++;
                push(cmd_frames[fr][frame_pos], 1'b1, 1'b0, ST_OK);
            end else if (fr == FR_ACMD41) begin
                ticks_seen = '0;
                if (wait_ticks == 16'd0)
                    start_poll(PH_P_ACMD41);
                else
                    phase = PH_W_ACMD41;
            end else begin
                start_poll(poll_ph);
            end
        endfunction

        function t_match match_reply(t_reply rp, t_byte rx);
            if (rx != reply_tbl[rp][reply_pos])
                return MATCH_FAIL;
            if (reply_pos < 2'd3) begin
                reply_pos++;
                return MATCH_MORE;
            end
            return MATCH_DONE;
        endfunction

        function bit poll_spent();
            logic [7:0] lim;
            lim = (poll_lim == 8'd0) ? 8'd1 : poll_lim;
            if (polls < 8'd255)
                polls++;
            return polls >= lim;
        endfunction

        function void note_input(t_mode m, t_byte rx);
            noted++;
            if (m == MODE_START) begin
                frame_pos = '0;
                reply_pos = '0;
                polls = '0;
                ticks_seen = '0;
                pre_sent = '0;
                if (pre_bytes == 8'd0) begin
                    start_frame(PH_F_CMD0, FR_CMD0);
                end else begin
                    phase = PH_PRE;
                    pre_sent = 8'd1;
                    push(IDLE_BYTE, 1'b0, 1'b0, ST_OK);
                end
                return;
            end
            if (m == MODE_TICK) begin
                if (phase == PH_W_ACMD41) begin
                    ticks_seen++;
                    if (ticks_seen >= wait_ticks)
                        start_poll(PH_P_ACMD41);
                end
                return;
            end
            if (m != MODE_BYTE)
                return;

            case (phase)
                PH_PRE: begin
                    if (pre_sent < pre_bytes) begin
                        pre_sent++;
                        push(IDLE_BYTE, 1'b0, 1'b0, ST_OK);
                    end else begin
                        start_frame(PH_F_CMD0, FR_CMD0);
                    end
                end
                PH_F_CMD0: next_frame_byte(FR_CMD0, PH_P_CMD0);
                PH_P_CMD0: begin
                    if (rx == R1_IDLE)
                        start_frame(PH_F_CMD8, FR_CMD8);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_F_CMD8: next_frame_byte(FR_CMD8, PH_P_CMD8);
                PH_P_CMD8: begin
                    if (rx == R1_IDLE)
                        start_reply(PH_R_CMD8);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_R_CMD8: begin
                    case (match_reply(RP_ECHO8, rx))
                        MATCH_FAIL: finish_seq(ST_CMD8_ECHO);
                        MATCH_MORE: push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                        default:    start_frame(PH_F_CHK, FR_CMD58);
                    endcase
                end
                PH_F_CHK: next_frame_byte(FR_CMD58, PH_P_CHK);
                PH_P_CHK: begin
                    if (rx == R1_READY)
                        start_reply(PH_R_CHK);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_R_CHK: begin
                    case (match_reply(RP_CHK58, rx))
                        MATCH_FAIL: finish_seq(ST_CMD58_CHK);
                        MATCH_MORE: push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                        default:    start_frame(PH_F_CMD55, FR_CMD55);
                    endcase
                end
                PH_F_CMD55: next_frame_byte(FR_CMD55, PH_P_CMD55);
                PH_P_CMD55: begin
                    if (rx <= R1_IDLE)
                        start_frame(PH_F_ACMD41, FR_ACMD41);
                    else if (poll_spent())
                        finish_seq(ST_CMD55_TO);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_F_ACMD41: next_frame_byte(FR_ACMD41, PH_P_ACMD41);
                PH_P_ACMD41: begin
                    if (rx == R1_READY)
                        start_frame(PH_F_OCR, FR_CMD58);
                    else if (rx == R1_IDLE)
                        start_frame(PH_F_CMD55, FR_CMD55);
                    else if (poll_spent())
                        finish_seq(ST_ACMD41_TO);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_F_OCR: next_frame_byte(FR_CMD58, PH_P_OCR);
                PH_P_OCR: begin
                    if (rx == R1_READY)
                        start_reply(PH_R_OCR);
                    else
                        push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                end
                PH_R_OCR: begin
                    case (match_reply(RP_OCR58, rx))
                        MATCH_FAIL: finish_seq(ST_FINAL_OCR);
                        MATCH_MORE: push(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
                        default:    finish_seq(ST_OK);
                    endcase
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
        endfunction

        function void check_result(t_byte tx, logic sel, logic fin, t_status st);
            t_spi_word w;
            if (expected.size() == 0) begin
                errors++;
                $display("%0t: result word with none expected, got tx=%h sel=%b fin=%b st=%h",
                         $time, tx, sel, fin, st);
                return;
            end
            w = expected.pop_front();
            if (tx !== w.tx)
                flag("tx_byte", w.tx, tx);
            if (sel !== w.sel)
                flag("select_asserted", 8'(w.sel), 8'(sel));
            if (fin !== w.fin)
                flag("finished", 8'(w.fin), 8'(fin));
            if (st !== w.st)
                flag("status", 8'(w.st), 8'(st));
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_mode     i_mode = MODE_START;
    t_byte     i_rx_byte = 8'h00;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_byte     o_tx_byte;
    logic      o_select_asserted;
    logic      o_finished;
    t_status   o_status;
    logic      i_cfg_wr_en = 1'b0;
    t_cfg_idx  i_cfg_index = CFG_PREAMBLE;
    t_cfg_data i_cfg_data = '0;

    init_seq_scoreboard sb;

    int     cycle_count = 0;
    bit     hold_req = 1'b0;
    int     hold_left = 0;
    int     stall_left = 0;
    t_stall stall_style = STALL_NONE;

    int     noise_pct = 0;
    int     err_pct = 0;
    int     poll_pct = 50;
    bit     fast_acmd = 1'b0;
    bit     stubborn = 1'b0;
    bit     gapless = 1'b0;

    sd_card_spi_init_sequencer_top u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sd_card_spi_init_sequencer_top");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a pattern of stall stretches
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(1, 48);
                case ($urandom_range(0, 3))
                    0, 1:    stall_style = STALL_NONE;
                    2:       stall_style = STALL_HALF;
                    default: stall_style = STALL_HEAVY;
                endcase
            end
            stall_left--;
            case (stall_style)
                STALL_NONE: i_out_ready <= 1'b1;
                STALL_HALF: i_out_ready <= 1'($urandom_range(0, 1));
                default:    i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_tx_byte, o_select_asserted, o_finished, o_status);
    end

    function automatic t_byte card_reply(t_reply rp, int roll);
        t_byte b;
        b = sb.reply_tbl[rp][sb.reply_pos];
        if (roll < err_pct)
            b = b ^ t_byte'($urandom_range(1, 255));
        return b;
    endfunction

    // play the card: mostly well-formed answers for the current step, some noise
    function automatic void pick_word(output t_mode m, output t_byte rx);
        t_byte junk;
        int    roll;
        junk = ($urandom_range(0, 1) != 0) ? IDLE_BYTE : t_byte'($urandom);
        m = MODE_BYTE;
        rx = junk;
        if ($urandom_range(0, 99) < noise_pct) begin
            case ($urandom_range(0, 3))
                0:       m = MODE_START;
                1:       m = MODE_TICK;
                2:       m = MODE_RSVD;
                default: m = MODE_BYTE;
            endcase
            return;
        end
        roll = $urandom_range(0, 99);
        case (sb.phase)
            PH_IDLE: m = MODE_START;
            PH_W_ACMD41: begin
                if (fast_acmd || roll < 90)
                    m = MODE_TICK;
            end
            PH_P_CMD0, PH_P_CMD8: begin
                if (roll < poll_pct)
                    rx = R1_IDLE;
                else if (junk == R1_IDLE)
                    rx = IDLE_BYTE;
            end
            PH_P_CHK, PH_P_OCR: begin
                if (roll < poll_pct)
                    rx = R1_READY;
                else if (junk == R1_READY)
                    rx = IDLE_BYTE;
            end
            PH_R_CMD8: rx = card_reply(RP_ECHO8, roll);
            PH_R_CHK:  rx = card_reply(RP_CHK58, roll);
            PH_R_OCR:  rx = card_reply(RP_OCR58, roll);
            PH_P_CMD55: begin
                if (!stubborn && roll < 65)
                    rx = t_byte'($urandom_range(0, 1));
                else if (junk <= R1_IDLE)
                    rx = t_byte'($urandom_range(2, 255));
            end
            PH_P_ACMD41: begin
                if (fast_acmd || (!stubborn && roll < 30))
                    rx = R1_READY;
                else if (!stubborn && roll < 60)
                    rx = R1_IDLE;
                else if (junk <= R1_IDLE)
                    rx = t_byte'($urandom_range(2, 255));
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(t_mode m, t_byte rx);
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(m, rx);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_LAT) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg_data data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_cfg(idx, data);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int pre, int ticks, int lim);
        write_reg(CFG_PREAMBLE, {8'($urandom), 8'(pre)});
        write_reg(CFG_ACMD_WAIT, t_cfg_data'(ticks));
        write_reg(CFG_POLL_LIM, {8'($urandom), 8'(lim)});
        write_reg(CFG_UNUSED, t_cfg_data'($urandom));
    endtask

    task automatic run_phase(int result_goal, int finish_goal);
        int    res0;
        int    fin0;
        int    burst_left;
        int    gap;
        t_mode m;
        t_byte rx;
        res0 = sb.predicted;
        fin0 = sb.predicted_finishes;
        burst_left = 0;
        while (sb.predicted - res0 < result_goal &&
               sb.predicted_finishes - fin0 < finish_goal) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap = 0;
                if (!gapless && $urandom_range(0, 3) != 0)
                    gap = $urandom_range(1, 8);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            pick_word(m, rx);
            send_word(m, rx);
        end
        drain();
    endtask

    task automatic set_knobs(int noise, int err, bit fast, bit hard, bit tight);
        noise_pct = noise;
        err_pct = err;
        fast_acmd = fast;
        stubborn = hard;
        gapless = tight;
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_TICK, 8'h5A);
        send_word(MODE_RSVD, 8'hA5);
        send_word(MODE_START, 8'h00);
        send_word(MODE_BYTE, 8'hFF);
        send_word(MODE_TICK, 8'h00);
        send_word(MODE_RSVD, 8'hFF);
        send_word(MODE_START, 8'hFF);
        send_word(MODE_BYTE, 8'h00);
        send_word(MODE_BYTE, 8'h80);
        send_word(MODE_BYTE, 8'h7F);
        drain();

        set_knobs(3, 5, 1'b0, 1'b0, 1'b0);
        run_phase(200, 1000);

        configure(0, 0, 0);
        run_phase(250, 1000);

        configure(1, 1, 1);
        run_phase(200, 1000);

        set_knobs(0, 0, 1'b1, 1'b0, 1'b1);
        configure(255, 120, 255);
        run_phase(1_000_000, 1);

        set_knobs(0, 0, 1'b0, 1'b1, 1'b0);
        configure(1, 0, 255);
        run_phase(1_000_000, 1);

        set_knobs(3, 5, 1'b0, 1'b0, 1'b1);
        configure(2, 1, 3);
        hold_req = 1'b1;
        run_phase(200, 1000);

        while (sb.noted < WORD_GOAL) begin
            set_knobs($urandom_range(0, 4), $urandom_range(2, 8), 1'b0, 1'b0,
                      ($urandom_range(0, 3) == 0));
            configure($urandom_range(0, 12),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 4),
                      $urandom_range(0, 6));
            run_phase(150, 1000);
        end

        if (sb.errors == 0 && sb.expected.size() == 0)
            $display("PASS sd_card_spi_init_sequencer_top");
        else
            $display("FAIL sd_card_spi_init_sequencer_top");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/sdci_pkg.sv
src/sd_card_spi_init_sequencer_top.sv
verif/sd_card_spi_init_sequencer_top_tb.sv
